// ----- rtl/fpc_pkg.sv -----
// Package: shared types and constants for the fern posterior classifier.
`timescale 1ns / 1ps

package fpc_pkg;

    localparam int SCORE_W   = 20;
    localparam int WEIGHT_W  = 17;
    localparam int COUNT_W   = 16;
    localparam int LEAF_W    = 13;
    localparam int ENTRY_W   = WEIGHT_W + 2 * COUNT_W;
    localparam int TOTAL_W   = COUNT_W + 1;
    localparam int NUM_W     = 2 * COUNT_W;
    localparam int DIV_CNT_W = $clog2(NUM_W);
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 24;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = SCORE_W;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_THRESH = 2'd1;

    localparam logic [SCORE_W-1:0] THRESH_RESET = 20'd327680;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 16'hFFFF;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_ACCUM,
        ST_DECIDE,
        ST_TR_READ,
        ST_TR_WAIT,
        ST_TR_DIV,
        ST_TR_WRITE,
        ST_EMIT
    } fpc_state_t;

    typedef struct packed {
        logic in_ready;
        logic clear_step;
        logic lookup;
        logic accum;
        logic decide;
        logic rd_train;
        logic load_div;
        logic div_step;
        logic wr_train;
        logic emit;
    } fpc_cmd_t;

    typedef struct packed {
        logic in_accept;
        logic in_last;
        logic pos_full;
        logic last_reg;
        logic train;
        logic div_last;
        logic train_last;
        logic clear_done;
        logic out_free;
    } fpc_status_t;

endpackage

// ----- rtl/fpc_datapath.sv -----
// Datapath: leaf table memory, score accumulator, per-leaf trainer with serial divider.
`timescale 1ns / 1ps

module fpc_datapath #(
    parameter int NUM_TREES = 10,
    parameter int LEAF_BITS = 13
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fpc_pkg::fpc_cmd_t                 cmd,
    output fpc_pkg::fpc_status_t              status,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpc_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fpc_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                              m_tuser,
    input  logic                              cfg_wr_en,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import fpc_pkg::*;

    localparam int TW    = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
    localparam int AW    = TW + LEAF_BITS;
    localparam int DEPTH = NUM_TREES << LEAF_BITS;
    localparam int PW    = $clog2(NUM_TREES + 1);

    logic [ENTRY_W-1:0]   mem [DEPTH];
    logic [ENTRY_W-1:0]   rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [ENTRY_W-1:0]   wr_data;
    logic                 wr_en;

    logic [SCORE_W-1:0]   pos_thresh_reg;
    logic [SCORE_W-1:0]   neg_thresh_reg;

    logic                 cmd_in_reg;
    logic                 label_reg;
    logic                 last_reg;
    logic [LEAF_BITS-1:0] leaf_reg;
    logic [LEAF_BITS-1:0] leaves_reg [NUM_TREES];
    logic [LEAF_BITS+LEAF_W-1:0] leaf_ext;

    logic [PW-1:0]        pos_reg;
    logic [PW-1:0]        t_reg;
    logic [SCORE_W-1:0]   score_reg;
    logic                 train_reg;
    logic [AW-1:0]        clr_addr_reg;

    logic [COUNT_W-1:0]   np_reg;
    logic [COUNT_W-1:0]   nn_reg;
    logic [TOTAL_W-1:0]   total_reg;
    logic [NUM_W-1:0]     num_reg;
    logic [TOTAL_W-1:0]   rem_reg;
    logic [WEIGHT_W-1:0]  q_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    logic                 out_valid_reg;
    logic [SCORE_W-1:0]   out_score_reg;
    logic                 out_trained_reg;

    logic [COUNT_W-1:0]   np_old;
    logic [COUNT_W-1:0]   nn_old;
    logic [COUNT_W-1:0]   np_new;
    logic [COUNT_W-1:0]   nn_new;
    logic [TOTAL_W-1:0]   total_new;
    logic [TOTAL_W:0]     rem_sh;
    logic [SCORE_W:0]     sum;
    logic                 train_now;
    logic [LEAF_BITS-1:0] train_leaf;
    logic                 accept;

    assign accept   = s_tvalid && cmd.in_ready;
    assign s_tready = cmd.in_ready;
    assign leaf_ext = {{LEAF_BITS{1'b0}}, s_tdata[LEAF_W+1:2]};

    assign train_leaf = leaves_reg[t_reg[TW-1:0]];
    assign rd_addr = cmd.rd_train ? {t_reg[TW-1:0], train_leaf}
                                  : {pos_reg[TW-1:0], leaf_reg};

    assign np_old    = rd_data_reg[COUNT_W-1:0];
    assign nn_old    = rd_data_reg[2*COUNT_W-1:COUNT_W];
    assign np_new    = (label_reg && np_old != COUNT_MAX) ? np_old + 1'b1 : np_old;
    assign nn_new    = (!label_reg && nn_old != COUNT_MAX) ? nn_old + 1'b1 : nn_old;
    assign total_new = {1'b0, np_new} + {1'b0, nn_new};
    assign rem_sh    = {rem_reg, num_reg[NUM_W-1]};

    assign sum = {1'b0, score_reg} + (SCORE_W + 1)'(rd_data_reg[ENTRY_W-1:2*COUNT_W]);
    assign train_now = cmd_in_reg && (label_reg ? (score_reg <= pos_thresh_reg)
                                                : (score_reg >= neg_thresh_reg));

    always_comb begin
        wr_en   = cmd.clear_step || cmd.wr_train;
        wr_addr = cmd.clear_step ? clr_addr_reg : {t_reg[TW-1:0], train_leaf};
        wr_data = cmd.clear_step ? '0 : {q_reg, nn_reg, np_reg};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_thresh_reg <= THRESH_RESET;
            neg_thresh_reg <= THRESH_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_POS_THRESH) begin
                pos_thresh_reg <= cfg_wr_data;
            end else if (cfg_index == CFG_NEG_THRESH) begin
                neg_thresh_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_in_reg <= s_tdata[0];
            label_reg  <= s_tdata[1];
            leaf_reg   <= leaf_ext[LEAF_BITS-1:0];
        end
        if (cmd.lookup) begin
            leaves_reg[pos_reg[TW-1:0]] <= leaf_reg;
        end
        if (cmd.load_div) begin
            np_reg      <= np_new;
            nn_reg      <= nn_new;
            total_reg   <= total_new;
            num_reg     <= {np_new, {COUNT_W{1'b0}}} + NUM_W'(total_new >> 1);
            rem_reg     <= '0;
            q_reg       <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_step) begin
            num_reg     <= num_reg << 1;
            div_cnt_reg <= div_cnt_reg + 1'b1;
            if (rem_sh >= {1'b0, total_reg}) begin
                rem_reg <= TOTAL_W'(rem_sh - {1'b0, total_reg});
                q_reg   <= {q_reg[WEIGHT_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[TOTAL_W-1:0];
                q_reg   <= {q_reg[WEIGHT_W-2:0], 1'b0};
            end
        end
        if (cmd.emit) begin
            out_score_reg   <= score_reg;
            out_trained_reg <= train_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg      <= 1'b0;
            pos_reg       <= '0;
            t_reg         <= '0;
            score_reg     <= '0;
            train_reg     <= 1'b0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                last_reg <= s_tlast;
            end
            if (cmd.clear_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.accum) begin
                score_reg <= sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
                pos_reg   <= pos_reg + 1'b1;
            end
            if (cmd.decide) begin
                train_reg <= train_now;
                t_reg     <= '0;
            end
            if (cmd.wr_train) begin
                t_reg <= t_reg + 1'b1;
            end
            if (cmd.emit) begin
                pos_reg       <= '0;
                score_reg     <= '0;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        status.in_accept  = accept;
        status.in_last    = s_tlast;
        status.pos_full   = (pos_reg == PW'(NUM_TREES));
        status.last_reg   = last_reg;
        status.train      = train_now;
        status.div_last   = (div_cnt_reg == DIV_CNT_W'(NUM_W - 1));
        status.train_last = (t_reg + 1'b1 == pos_reg);
        status.clear_done = (clr_addr_reg == AW'(DEPTH - 1));
        status.out_free   = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_score_reg);
    assign m_tuser  = out_trained_reg;

endmodule

// ----- rtl/fpc_controller.sv -----
// Controller: state machine sequencing clear, lookup, training and result delivery.
`timescale 1ns / 1ps

module fpc_controller (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fpc_pkg::fpc_status_t status,
    output fpc_pkg::fpc_cmd_t    cmd
);
    import fpc_pkg::*;

    fpc_state_t state_reg;
    fpc_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (status.in_accept) begin
                    if (!status.pos_full) begin
                        state_next = ST_LOOKUP;
                    end else if (status.in_last) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_LOOKUP: begin
                cmd.lookup = 1'b1;
                state_next = ST_ACCUM;
            end
            ST_ACCUM: begin
                cmd.accum  = 1'b1;
                state_next = status.last_reg ? ST_DECIDE : ST_IDLE;
            end
            ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = status.train ? ST_TR_READ : ST_EMIT;
            end
            ST_TR_READ: begin
                cmd.rd_train = 1'b1;
                state_next   = ST_TR_WAIT;
            end
            ST_TR_WAIT: begin
                cmd.load_div = 1'b1;
                state_next   = ST_TR_DIV;
            end
            ST_TR_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_TR_WRITE;
                end
            end
            ST_TR_WRITE: begin
                cmd.wr_train = 1'b1;
                state_next   = status.train_last ? ST_EMIT : ST_TR_READ;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- rtl/fern_posterior_classifier_unit.sv -----
// Top level: random-fern posterior classifier, controller plus datapath.
//
//  channel  | direction | tdata (low bit up)                   | tuser / tlast
//  s_       | in        | command, label, leaf_index, pad      | tlast = last_tree
//  m_       | out       | confidence, pad                      | tuser = trained
//  cfg_     | in        | 0 positive_threshold, 1 negative_threshold
//
// Each of the first NUM_TREES words passes through accept, table read and
// accumulate; the last word then goes through decide and emit. Training reads,
// divides with the 32-step serial divider and writes back each scored tree's leaf.
// After reset a clearing pass zeroes all NUM_TREES * 2^LEAF_BITS table entries;
// no word is accepted meanwhile. A stalled result holds the block in emit only.
`timescale 1ns / 1ps

module fern_posterior_classifier_unit #(
    parameter int NUM_TREES = 10,
    parameter int LEAF_BITS = 13
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fpc_pkg::S_DATA_W-1:0]      s_tdata,   // command, label, leaf_index
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fpc_pkg::M_DATA_W-1:0]      m_tdata,   // confidence
    output logic                              m_tuser,   // trained
    input  logic                              cfg_wr_en,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);
    import fpc_pkg::*;

    fpc_cmd_t    cmd;
    fpc_status_t status;

    fpc_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .cmd     (cmd)
    );

    fpc_datapath #(
        .NUM_TREES (NUM_TREES),
        .LEAF_BITS (LEAF_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

endmodule

// ----- tb/fern_score_checker.sv -----
// Checker: watches the word channels, predicts fern scores and training, compares results.
`timescale 1ns / 1ps

module fern_score_checker #(
    parameter int NUM_TREES = 10,
    parameter int LEAF_BITS = 13
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [fpc_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [fpc_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           m_tuser,
    input  logic                           cfg_wr_en,
    input  logic [fpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fpc_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output int                             errors,
    output int                             outstanding
);
    import fpc_pkg::*;

    localparam int LEAVES = 1 << LEAF_BITS;
    localparam int DEPTH  = NUM_TREES * LEAVES;

    typedef struct {
        logic [SCORE_W-1:0] confidence;
        logic               trained;
    } score_t;

    logic [COUNT_W-1:0]  pos_cnt [DEPTH];
    logic [COUNT_W-1:0]  neg_cnt [DEPTH];
    logic [WEIGHT_W-1:0] weight  [DEPTH];
    int                  leaves_seen [NUM_TREES];
    int                  tree_pos;
    logic [SCORE_W-1:0]  run_score;
    logic [SCORE_W-1:0]  pos_thresh;
    logic [SCORE_W-1:0]  neg_thresh;
    score_t              pending_scores[$];

    assign outstanding = pending_scores.size();

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        errors++;
    endtask

    task automatic train_leaf(input int slot, input bit positive);
        longint unsigned np;
        longint unsigned total;
        if (positive) begin
            if (pos_cnt[slot] != COUNT_MAX) pos_cnt[slot] = pos_cnt[slot] + 1'b1;
        end else begin
            if (neg_cnt[slot] != COUNT_MAX) neg_cnt[slot] = neg_cnt[slot] + 1'b1;
        end
        np    = pos_cnt[slot];
        total = np + neg_cnt[slot];
        if (np == 0)
            weight[slot] = '0;
        else
            weight[slot] = WEIGHT_W'((np * 65536 + total / 2) / total);
    endtask

    task automatic score_word(input logic [S_DATA_W-1:0] word, input logic last);
        logic               cmd;
        logic               lab;
        int                 leaf;
        int                 sum;
        bit                 train;
        score_t             res;
        cmd  = word[0];
        lab  = word[1];
        leaf = int'(word[2 +: LEAF_W]) & (LEAVES - 1);
        if (tree_pos < NUM_TREES) begin
            sum = int'(run_score) + int'(weight[tree_pos * LEAVES + leaf]);
            run_score = (sum > 20'hFFFFF) ? 20'hFFFFF : SCORE_W'(sum);
            leaves_seen[tree_pos] = leaf;
            tree_pos++;
        end
        if (!last) return;
        train = 0;
        if (cmd) train = lab ? (run_score <= pos_thresh) : (run_score >= neg_thresh);
        if (train)
            for (int t = 0; t < tree_pos; t++) train_leaf(t * LEAVES + leaves_seen[t], lab);
        res.confidence = run_score;
        res.trained    = train;
        pending_scores.insert(pending_scores.size(), res);
        tree_pos  = 0;
        run_score = '0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                pos_cnt[i] = '0;
                neg_cnt[i] = '0;
                weight[i]  = '0;
            end
            errors     = 0;
            tree_pos   = 0;
            run_score  = '0;
            pos_thresh = THRESH_RESET;
            neg_thresh = THRESH_RESET;
            pending_scores.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_POS_THRESH) pos_thresh = cfg_wr_data;
                else if (cfg_index == CFG_NEG_THRESH) neg_thresh = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                if (pending_scores.size() == 0) begin
                    flag_mismatch("result word with nothing expected");
                end else begin
                    score_t e;
                    e = pending_scores.pop_front();
                    if (m_tdata[SCORE_W-1:0] !== e.confidence)
                        flag_mismatch($sformatf("confidence %0d, expected %0d",
                                                m_tdata[SCORE_W-1:0], e.confidence));
                    if (m_tuser !== e.trained)
                        flag_mismatch($sformatf("trained %0b, expected %0b",
                                                m_tuser, e.trained));
                end
            end
            if (s_tvalid && s_tready) score_word(s_tdata, s_tlast);
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top: clock, reset, word stimulus, register writes and verdict.
`timescale 1ns / 1ps

module tb_top;
    import fpc_pkg::*;

    localparam int NUM_TREES  = 10;
    localparam int IDLE_LIMIT = 250000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tuser;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    int                    errors;
    int                    outstanding;
    int                    idle_pct;
    int                    stall_pct;
    int                    hold_cycles;
    int                    quiet_cycles;
    bit                    hold_go;
    bit                    hold_used;

    fern_posterior_classifier_unit uut (.*);

    fern_score_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        if (hold_go && !hold_used) begin
            hold_used   <= 1'b1;
            hold_cycles <= 500;
            m_tready    <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("** fern_posterior_classifier_unit: FAILED **");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic cmd, input logic lab, input int leaf, input logic last);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, LEAF_W'(leaf), lab, cmd};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // leaf < 0 picks random leaves
    task automatic send_pattern(input int len, input logic cmd, input logic lab, input int leaf);
        int  lf;
        int  pick;
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(99);
            if (leaf >= 0) lf = leaf;
            else if (pick < 65) lf = $urandom_range(7);
            else if (pick < 88) lf = $urandom_range(8191);
            else lf = (pick & 1) ? 8191 : 0;
            if (i == len - 1) send_word(cmd, lab, lf, 1'b1);
            else send_word($urandom_range(1), $urandom_range(1), lf, 1'b0);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= CFG_DATA_W'(val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 80) len = NUM_TREES;
            else if (pick < 90) len = $urandom_range(1, NUM_TREES - 1);
            else len = $urandom_range(NUM_TREES + 1, NUM_TREES + 3);
            send_pattern(len, ($urandom_range(99) < 70), $urandom_range(1), -1);
            sent += len;
        end
    endtask

    initial begin
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wr_data  = '0;
        idle_pct     = 0;
        stall_pct    = 0;
        hold_go      = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: single tree, all-zero and all-one leaves, long and short patterns
        send_pattern(1, 1'b1, 1'b1, 8191);
        send_pattern(NUM_TREES, 1'b1, 1'b1, 0);
        send_pattern(NUM_TREES + 2, 1'b0, 1'b0, 8191);
        send_pattern(2, 1'b1, 1'b0, 0);
        settle();

        write_reg(CFG_POS_THRESH, 655360);
        write_reg(CFG_NEG_THRESH, 0);
        random_phase(390);
        settle();

        idle_pct = 45;
        write_reg(CFG_POS_THRESH, 0);
        write_reg(CFG_NEG_THRESH, 655360);
        write_reg(CFG_SPARE_A, $urandom);
        write_reg(CFG_SPARE_B, $urandom);
        random_phase(390);
        settle();

        idle_pct  = 0;
        stall_pct = 45;
        write_reg(CFG_POS_THRESH, $urandom_range(655360));
        write_reg(CFG_NEG_THRESH, $urandom_range(655360));
        hold_go = 1'b1;
        random_phase(390);
        settle();

        idle_pct  = 17;
        stall_pct = 17;
        write_reg(CFG_POS_THRESH, $urandom_range(131072, 393216));
        write_reg(CFG_NEG_THRESH, $urandom_range(131072, 393216));
        random_phase(390);
        settle();

        idle_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_POS_THRESH, 327680);
        write_reg(CFG_NEG_THRESH, 327680);
        random_phase(390);
        settle();

        if (errors == 0) begin
            $display("** fern_posterior_classifier_unit: PASSED **");
        end else begin
            $display("** fern_posterior_classifier_unit: FAILED **");
        end
        $finish;
    end

endmodule
